/* hdl/gcr_pkg.sv */
package gcr_pkg;

	localparam logic [7:0] BlockId    = 8'h07;
	localparam logic [7:0] SectorLast = 8'hff;
	localparam int         GroupBytes = 5;

	localparam logic [4:0] NibbleCode [16] = '{
		5'h0a, 5'h0b, 5'h12, 5'h13,
		5'h0e, 5'h0f, 5'h16, 5'h17,
		5'h09, 5'h19, 5'h1a, 5'h1b,
		5'h0d, 5'h1d, 5'h1e, 5'h15
	};

	typedef struct packed {
		logic        valid;
		logic [39:0] word;
		logic        last;
	} group_t;

	function automatic logic [39:0] encode_group(input logic [31:0] grp);
		logic [39:0] bits;
		bits = '0;
		for (int k = 0; k < 8; k++) begin
			bits[39 - 5 * k -: 5] = NibbleCode[grp[31 - 4 * k -: 4]];
		end
		return bits;
	endfunction

endpackage

/* hdl/gcr_assemble.sv */
module gcr_assemble (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                take,
	output gcr_pkg::group_t     grp
);
	import gcr_pkg::*;

	logic [7:0]  pos_q;
	logic [23:0] hist_q;
	logic [7:0]  xor_q;
	group_t      pend_q;
	logic [7:0]  xor_next;
	logic        is_last;
	logic        completes;
	logic        accept;
	logic [31:0] bytes;

	assign xor_next  = xor_q ^ data_byte;
	assign is_last   = (pos_q == SectorLast);
	assign completes = is_last || (pos_q[1:0] == 2'd2);
	assign in_stall  = completes && pend_q.valid && !take;
	assign accept    = in_valid && !in_stall;
	assign grp       = pend_q;

	always_comb begin
		if (is_last) begin
			bytes = {data_byte, xor_next, 16'h0000};
		end else if (pos_q == 8'd2) begin
			bytes = {BlockId, hist_q[15:0], data_byte};
		end else begin
			bytes = {hist_q, data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hist_q <= '0;
			xor_q  <= '0;
			pend_q <= '0;
		end else begin
			if (accept) begin
				if (is_last) begin
					pos_q  <= '0;
					hist_q <= '0;
					xor_q  <= '0;
				end else begin
					pos_q  <= pos_q + 8'd1;
					hist_q <= {hist_q[15:0], data_byte};
					xor_q  <= xor_next;
				end
			end
			if (accept && completes) begin
				pend_q.valid <= 1'b1;
				pend_q.last  <= is_last;
				pend_q.word  <= encode_group(bytes);
			end else if (take) begin
				pend_q.valid <= 1'b0;
			end
		end
	end

endmodule

/* hdl/gcr_serialiser.sv */
module gcr_serialiser (
	input  logic                clk,
	input  logic                arst_n,
	input  gcr_pkg::group_t     grp,
	output logic                take,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          gcr_byte,
	output logic                last_of_run,
	output logic                end_of_block
);
	import gcr_pkg::*;

	logic [39:0] sh_q;
	logic [2:0]  cnt_q;
	logic        final_q;
	logic        out_take;

	assign out_valid    = (cnt_q != 3'd0);
	assign out_take     = out_valid && !out_stall;
	assign take         = grp.valid && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_take));
	assign gcr_byte     = sh_q[39:32];
	assign last_of_run  = (cnt_q == 3'd1);
	assign end_of_block = (cnt_q == 3'd1) && final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			final_q <= 1'b0;
		end else if (take) begin
			cnt_q   <= 3'(GroupBytes);
			final_q <= grp.last;
		end else if (out_take) begin
			cnt_q   <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sh_q <= grp.word;
		end else if (out_take) begin
			sh_q <= {sh_q[31:0], 8'h00};
		end
	end

endmodule

/* hdl/gcr_sector_encoder.sv */
// Encodes a 256-byte disk sector into its 325-byte 4-to-5 GCR data block. Bytes enter
// in sector order, one item a cycle unless stalled; every fourth byte from the third
// (and the final byte, which also closes the group carrying the checksum) completes a
// group of five output bytes. A group is encoded into a holding register, then shifted
// out one byte a cycle unless out_stall holds it, so the output port sets the pace; the
// input stalls only when a group completes while the previous one is still held.
module gcr_sector_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] gcr_byte,
	output logic       last_of_run,
	output logic       end_of_block
);
	import gcr_pkg::*;

	group_t grp;
	logic   take;

	gcr_assemble u_assemble (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.take      (take),
		.grp       (grp)
	);

	gcr_serialiser u_serialiser (
		.clk          (clk),
		.arst_n       (arst_n),
		.grp          (grp),
		.take         (take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.gcr_byte     (gcr_byte),
		.last_of_run  (last_of_run),
		.end_of_block (end_of_block)
	);

endmodule

/* hdl/gcr_checker.sv */
module gcr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] data_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] gcr_byte,
	input logic       last_of_run,
	input logic       end_of_block
);
	logic [2:0] run_q;
	logic [8:0] blk_q;
	logic       out_take;

	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			blk_q <= '0;
		end else if (out_take) begin
			run_q <= (run_q == 3'd4) ? 3'd0 : run_q + 3'd1;
			blk_q <= (blk_q == 9'd324) ? 9'd0 : blk_q + 9'd1;
		end
	end

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_block |-> last_of_run)
		else $error("end of block without end of run");

	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_run == (run_q == 3'd4)))
		else $error("run of output items is not five long");

	a_block_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (end_of_block == (blk_q == 9'd324)))
		else $error("block of output items is not 325 long");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(gcr_byte)
			&& $stable(last_of_run) && $stable(end_of_block))
		else $error("stalled output item changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(data_byte))
		else $error("stalled input item changed");

endmodule

bind gcr_sector_encoder gcr_checker u_gcr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.data_byte    (data_byte),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.gcr_byte     (gcr_byte),
	.last_of_run  (last_of_run),
	.end_of_block (end_of_block)
);

/* tb/sv/gcr_sector_checker.sv */
module gcr_sector_checker
	import gcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] gcr_byte,
	input  logic       last_of_run,
	input  logic       end_of_block,
	output int         errors,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] code;
		logic       run_end;
		logic       block_end;
	} gcr_result_t;

	localparam logic [4:0] FiveBit [16] = '{
		5'h0a, 5'h0b, 5'h12, 5'h13,
		5'h0e, 5'h0f, 5'h16, 5'h17,
		5'h09, 5'h19, 5'h1a, 5'h1b,
		5'h0d, 5'h1d, 5'h1e, 5'h15
	};

	gcr_result_t gcr_due[$];
	logic [7:0]  next_pos = '0;
	logic [23:0] held_bytes = '0;
	logic [7:0]  sector_xor = '0;

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic logic [39:0] gcr_word(input logic [31:0] grp);
		logic [39:0] bits;
		bits = '0;
		for (int k = 0; k < 8; k++) begin
			bits = {bits[34:0], FiveBit[grp[31 - 4 * k -: 4]]};
		end
		return bits;
	endfunction

	task automatic push_group(input logic [31:0] grp, input logic closes_block);
		logic [39:0] word;
		word = gcr_word(grp);
		for (int k = 0; k < GroupBytes; k++) begin
			gcr_due.push_back(gcr_result_t'{word[39 - 8 * k -: 8], k == 4,
				k == 4 && closes_block});
		end
	endtask

	task automatic report(input string what);
		$display("%0t ns: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] b;
		gcr_result_t want;
		if (!arst_n) begin
			next_pos = '0;
			held_bytes = '0;
			sector_xor = '0;
			gcr_due.delete();
			pending = 0;
		end else begin
			if (in_valid && !in_stall) begin
				b = data_byte;
				sector_xor = sector_xor ^ b;
				if (next_pos == SectorLast) begin
					push_group({b, sector_xor, 16'h0000}, 1'b1);
					next_pos = '0;
					held_bytes = '0;
					sector_xor = '0;
				end else begin
					if (next_pos[1:0] == 2'd2) begin
						push_group({(next_pos == 8'd2) ? BlockId : held_bytes[23:16],
							held_bytes[15:0], b}, 1'b0);
					end
					held_bytes = {held_bytes[15:0], b};
					next_pos = next_pos + 8'd1;
				end
			end
			if (out_valid && !out_stall) begin
				if (gcr_due.size() == 0) begin
					report($sformatf("unexpected item: gcr_byte %02h", gcr_byte));
				end else begin
					want = gcr_due.pop_front();
					if (gcr_byte !== want.code)
						report($sformatf("gcr_byte: got %02h, want %02h", gcr_byte,
							want.code));
					if (last_of_run !== want.run_end)
						report($sformatf("last_of_run: got %b, want %b", last_of_run,
							want.run_end));
					if (end_of_block !== want.block_end)
						report($sformatf("end_of_block: got %b, want %b", end_of_block,
							want.block_end));
				end
			end
			pending = gcr_due.size();
		end
	end

endmodule

/* tb/sv/gcr_sector_encoder_tb.sv */
module gcr_sector_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SectorBytes = 256;
	localparam int TotalBytes  = SectorBytes + 104;
	localparam int CalmFrom    = TotalBytes - 60;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] gcr_byte;
	logic       last_of_run;
	logic       end_of_block;
	int         errors;
	int         pending;
	logic       calm = 1'b0;

	logic [7:0] opening_bytes [24] = '{
		8'h00, 8'hff, 8'h80, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89,
		8'hab, 8'hcd, 8'hef, 8'hfe, 8'hdc, 8'hba, 8'h98, 8'h76,
		8'h54, 8'h32, 8'h10, 8'h7f, 8'h55, 8'haa, 8'h0f, 8'hf0
	};

	always #5 clk = ~clk;

	gcr_sector_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.gcr_byte     (gcr_byte),
		.last_of_run  (last_of_run),
		.end_of_block (end_of_block)
	);

	gcr_sector_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.gcr_byte     (gcr_byte),
		.last_of_run  (last_of_run),
		.end_of_block (end_of_block),
		.errors       (errors),
		.pending      (pending)
	);

	task automatic drive_byte(input logic [7:0] value);
		int gap;
		gap = $urandom_range(1, 10);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	initial begin
		int burst;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			burst = $urandom_range(1, 10);
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				repeat (burst) @(posedge clk);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int n = 0; n < TotalBytes; n++) begin
			calm <= (n >= CalmFrom);
			if (n < 24)
				drive_byte(opening_bytes[n]);
			else
				drive_byte(8'($urandom_range(0, 255)));
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
hdl/gcr_pkg.sv
hdl/gcr_assemble.sv
hdl/gcr_serialiser.sv
hdl/gcr_sector_encoder.sv
hdl/gcr_checker.sv
tb/sv/gcr_sector_checker.sv
tb/sv/gcr_sector_encoder_tb.sv
